// File: rtl/core/eaed_pkg.sv
`default_nettype none

package eaed_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_BITS_DEF    = 48;

    // distance result and limit
    localparam int                   DIST_BITS  = 24;
    localparam logic [DIST_BITS-1:0] DIST_MAX   = 24'hFFFFFF;
    localparam int                   LIM2_BITS  = 2 * DIST_BITS;
    // square of the reset distance ceiling
    localparam logic [LIM2_BITS-1:0] LIM2_RESET = 48'hFFFF_FE00_0001;

    // configuration register indexes
    localparam int                      CFG_IDX_BITS     = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIST_CEILING = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic load_pair;
        logic square;
        logic accumulate;
        logic clear_sum;
        logic root_start;
        logic load_abandon;
        logic load_distance;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic abandon;
        logic root_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/core/eaed_isqrt.sv
`default_nettype none

module eaed_isqrt
    import eaed_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [SUM_BITS-1:0]          i_radicand,
    output logic [(SUM_BITS+1)/2-1:0]    o_root,
    output logic                         o_done
);

    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

    logic [2*ROOT_BITS-1:0] r_x;
    logic [ROOT_BITS+1:0]   r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [CNT_BITS-1:0]    r_count;
    logic                   r_done;

    logic [ROOT_BITS+1:0]   rem_shift;
    logic [ROOT_BITS+1:0]   trial;

    // one root bit per step, two radicand bits brought down
    assign rem_shift = {r_rem[ROOT_BITS-1:0], r_x[2*ROOT_BITS-1 -: 2]};
    assign trial     = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_count <= CNT_BITS'(ROOT_BITS);
            r_done  <= 1'b0;
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
            if (r_count == CNT_BITS'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= (2*ROOT_BITS)'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_count != '0) begin
            r_x <= {r_x[2*ROOT_BITS-3:0], 2'b00};
            if (rem_shift >= trial) begin
                r_rem  <= rem_shift - trial;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_shift;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: rtl/core/eaed_datapath.sv
`default_nettype none

module eaed_datapath
    import eaed_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_a,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_b,
    input  wire                           i_last_pair,
    input  wire                           i_cfg_valid,
    input  wire  [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire  [DIST_BITS-1:0]          i_cfg_data,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [DIST_BITS-1:0]          o_distance,
    output logic                          o_abandoned
);

    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int ADD_BITS  = ((SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS) + 1;
    localparam int CMP_BITS  = (SUM_BITS > LIM2_BITS) ? SUM_BITS : LIM2_BITS;
    localparam int SAT_BITS  = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    logic                   r_limit_enable;
    logic [LIM2_BITS-1:0]   r_lim2;
    logic [SAMPLE_BITS-1:0] r_diff;
    logic                   r_last;
    logic [SQ_BITS-1:0]     r_sq;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_out_valid;
    logic [DIST_BITS-1:0]   r_distance;
    logic                   r_abandoned;

    logic [SAMPLE_BITS:0]   diff_full;
    logic [SAMPLE_BITS:0]   abs_full;
    logic [ADD_BITS-1:0]    sum_wide;
    logic [SUM_BITS-1:0]    sum_sat;
    logic [ROOT_BITS-1:0]   root;
    logic                   root_done;
    logic [SAT_BITS-1:0]    root_ext;
    logic [DIST_BITS-1:0]   dist_sat;

    // absolute difference of the pair
    assign diff_full = {i_sample_a[SAMPLE_BITS-1], i_sample_a}
                     - {i_sample_b[SAMPLE_BITS-1], i_sample_b};
    assign abs_full  = diff_full[SAMPLE_BITS] ? -diff_full : diff_full;

    // saturating accumulate
    assign sum_wide = ADD_BITS'(r_sum) + ADD_BITS'(r_sq);
    assign sum_sat  = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    assign root_ext = SAT_BITS'(root);
    assign dist_sat = (root_ext > SAT_BITS'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_BITS-1:0];

    // configuration, limit kept squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_enable <= 1'b0;
            r_lim2         <= LIM2_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LIMIT_ENABLE: r_limit_enable <= i_cfg_data[0];
                CFG_DIST_CEILING: r_lim2 <= LIM2_BITS'(i_cfg_data) * LIM2_BITS'(i_cfg_data);
                default:          r_limit_enable <= r_limit_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pair) begin
            r_diff <= abs_full[SAMPLE_BITS-1:0];
            r_last <= i_last_pair;
        end
        if (i_cmd.square) begin
            r_sq <= SQ_BITS'(r_diff) * SQ_BITS'(r_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.clear_sum) begin
            r_sum <= '0;
        end else if (i_cmd.accumulate) begin
            r_sum <= sum_sat;
        end
    end

    eaed_isqrt #(
        .SUM_BITS (SUM_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand (r_sum),
        .o_root     (root),
        .o_done     (root_done)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_abandon || i_cmd.load_distance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_abandon) begin
            r_distance  <= '0;
            r_abandoned <= 1'b1;
        end else if (i_cmd.load_distance) begin
            r_distance  <= dist_sat;
            r_abandoned <= 1'b0;
        end
    end

    always_comb begin
        o_status.last      = r_last;
        o_status.abandon   = r_limit_enable && (CMP_BITS'(r_sum) > CMP_BITS'(r_lim2));
        o_status.root_done = root_done;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_abandoned = r_abandoned;

endmodule

`default_nettype wire

// File: rtl/core/eaed_ctrl.sv
`default_nettype none

module eaed_ctrl
    import eaed_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_last_pair,
    output logic       o_in_ready,
    output logic       o_discarding,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SQUARE = 5'b00010,
        S_ACCUM  = 5'b00100,
        S_CHECK  = 5'b01000,
        S_ROOT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_discarding;
    logic   n_discarding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_discarding <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_discarding <= n_discarding;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_discarding = r_discarding;
        o_cmd        = '0;
        o_in_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_discarding) begin
                        // dropped pair, the last one ends the drop
                        if (i_last_pair) begin
                            n_discarding    = 1'b0;
                            o_cmd.clear_sum = 1'b1;
                        end
                    end else begin
                        o_cmd.load_pair = 1'b1;
                        n_state         = S_SQUARE;
                    end
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accumulate = 1'b1;
                n_state          = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.abandon) begin
                    if (i_status.out_free) begin
                        o_cmd.load_abandon = 1'b1;
                        o_cmd.clear_sum    = 1'b1;
                        n_discarding       = !i_status.last;
                        n_state            = S_IDLE;
                    end
                end else if (i_status.last) begin
                    o_cmd.root_start = 1'b1;
                    o_cmd.clear_sum  = 1'b1;
                    n_state          = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (i_status.root_done && i_status.out_free) begin
                    o_cmd.load_distance = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_discarding = r_discarding;

endmodule

`default_nettype wire

// File: rtl/core/early_abandon_euclidean_distance_unit.sv
// Early-abandoning Euclidean distance. Element pairs of two vectors arrive one
// transaction at a time, the last pair flagged; the unit sums squared
// differences in a saturating SUM_BITS accumulator and on the last pair returns
// the floor square root of the sum, saturated to 24 bits. With limit_enable set,
// once the sum exceeds the distance ceiling squared it returns, when the output
// register is free, a result with abandoned = 1 and distance = 0, and unless
// that pair was the last it drops further pairs up to and including the last
// pair. An accumulated pair passes through the accept, square, accumulate and
// limit check states, the multiply, the add and the compare each in a state of
// their own; the last pair then goes through the iterative square root, which
// yields one root bit per cycle. A dropped pair skips the datapath. The result
// sits in an output register, so work goes on while it waits to be taken.
`default_nettype none

module early_abandon_euclidean_distance_unit
    import eaed_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // pair transactions
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_a,
    input  wire  signed [SAMPLE_BITS-1:0] i_sample_b,
    input  wire                           i_last_pair,
    // result transactions
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [DIST_BITS-1:0]          o_distance,
    output logic                          o_abandoned,
    // register writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire  [DIST_BITS-1:0]          i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       discarding;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencing: one pair in flight, drop mode after an abandon
    eaed_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_pair  (i_last_pair),
        .o_in_ready   (o_in_ready),
        .o_discarding (discarding),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    // difference, square, accumulator, limit compare, square root, result register
    eaed_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_last_pair (i_last_pair),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_abandoned (o_abandoned)
    );

    // an abandoned result always carries a zero distance
    a_abandon_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_abandoned) |-> (o_distance == '0))
        else $error("abandoned result with non-zero distance");

    // a pair that is worked on keeps the input closed the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !discarding) |=> !o_in_ready)
        else $error("input open while a pair is in flight");

    // results are only produced from a busy state, never on an accepting cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result loaded while input was open");

endmodule

`default_nettype wire

// File: tb/early_abandon_euclidean_distance_unit_tb.sv
module early_abandon_euclidean_distance_unit_tb;
    import eaed_pkg::*;

    // widths follow the unit defaults
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int SUM_BITS    = SUM_BITS_DEF;

    // accept, square, accumulate, limit check, then the root iterations
    localparam int UNIT_LATENCY  = 4 + (SUM_BITS + 1) / 2 + 1;
    localparam int SETTLE_CYCLES = 2 * UNIT_LATENCY;
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam int RANDOM_PAIRS      = 1000;
    localparam int VECTORS_PER_PHASE = 10;
    // one long full-scale vector sent with no idling
    localparam int LONG_PAIRS        = 100;

    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // how widely random samples spread
    typedef enum logic [1:0] {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } t_sample_spread;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 abandoned;
    } t_dist_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // pair channel
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_a  = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_b  = '0;
    logic                          i_last_pair = 1'b0;

    // result channel
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DIST_BITS-1:0] o_distance;
    logic                 o_abandoned;

    // register write channel
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_LIMIT_ENABLE;
    logic [DIST_BITS-1:0]    i_cfg_data  = '0;

    // predictor state: registers, running sum and the drop flag
    logic                 lim_enable;
    logic [DIST_BITS-1:0] lim_value;
    logic [SUM_BITS-1:0]  run_sum;
    logic                 dropping;

    // distances still owed by the unit, oldest first
    t_dist_result pending_results[$];

    int errors      = 0;
    int cycle_count = 0;
    int out_hold    = 0;

    // stretches with no idling on either side
    logic in_gaps_off    = 1'b0;
    logic out_stalls_off = 1'b0;

    early_abandon_euclidean_distance_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_last_pair (i_last_pair),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_abandoned (o_abandoned),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("early_abandon_euclidean_distance_unit_tb NOT OK");
            $finish;
        end
    end

    // bitwise root search from the top bit down; a 48-bit sum never needs more than 24 bits
    function automatic logic [DIST_BITS-1:0] floor_sqrt(input logic [63:0] x);
        logic [DIST_BITS-1:0] root;
        logic [DIST_BITS-1:0] trial;
        root = '0;
        for (int i = DIST_BITS - 1; i >= 0; i--) begin
            trial = root | (DIST_BITS'(1) << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    // advance the predictor by one accepted pair and queue any distance it owes
    function automatic void predict_pair(input logic signed [SAMPLE_BITS-1:0] a,
                                         input logic signed [SAMPLE_BITS-1:0] b,
                                         input logic                          last);
        longint       diff;
        logic [63:0]  total;
        logic [63:0]  lim_sq;
        t_dist_result res;
        // after an abandon, pairs are dropped up to and including the last one
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                run_sum  = '0;
            end
            return;
        end
        diff = longint'(a) - longint'(b);
        if (diff < 0)
            diff = -diff;
        // saturating accumulate
        total   = 64'(run_sum) + 64'(diff * diff);
        run_sum = SUM_BITS'((total > SUM_MAX) ? SUM_MAX : total);
        lim_sq  = 64'(lim_value) * 64'(lim_value);
        if (lim_enable && 64'(run_sum) > lim_sq) begin
            res.distance  = '0;
            res.abandoned = 1'b1;
            pending_results.push_back(res);
            run_sum  = '0;
            dropping = !last;
        end else if (last) begin
            res.distance  = floor_sqrt(64'(run_sum));
            res.abandoned = 1'b0;
            pending_results.push_back(res);
            run_sum = '0;
        end
    endfunction

    // one monitor for all three channels: results are checked before the
    // pair of the same edge is predicted, so the order is fixed
    always @(posedge i_clk) begin : monitor
        t_dist_result want;
        if (!i_rst_n) begin
            lim_enable = 1'b0;
            lim_value  = DIST_MAX;
            run_sum    = '0;
            dropping   = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual distance %0d abandoned %0b",
                             $time, o_distance, o_abandoned);
                end else begin
                    want = pending_results.pop_front();
                    if (o_distance !== want.distance) begin
                        errors++;
                        $display("%0t: distance mismatch, expected %0d, actual %0d",
                                 $time, want.distance, o_distance);
                    end
                    if (o_abandoned !== want.abandoned) begin
                        errors++;
                        $display("%0t: abandoned mismatch, expected %0b, actual %0b",
                                 $time, want.abandoned, o_abandoned);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LIMIT_ENABLE)
                    lim_enable = i_cfg_data[0];
                else if (i_cfg_index == CFG_DIST_CEILING)
                    lim_value = i_cfg_data;
            end
            if (i_in_valid && o_in_ready)
                predict_pair(i_sample_a, i_sample_b, i_last_pair);
        end
    end

    // result side back-pressure: after a transaction, unless stalls are off, ready may go low for a random hold
    always @(posedge i_clk) begin : result_stall
        int hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
        end else if (i_out_ready) begin
            if (o_out_valid && !out_stalls_off) begin
                hold = $urandom_range(0, 6);
                if (hold != 0) begin
                    i_out_ready <= 1'b0;
                    out_hold    <= hold - 1;
                end
            end
        end else if (out_hold == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            out_hold <= out_hold - 1;
        end
    end

    // offer one pair after a random gap; valid stays up on return so that
    // back-to-back transactions never lower and raise it in one step
    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] a,
                             input logic signed [SAMPLE_BITS-1:0] b,
                             input logic                          last);
        int gap;
        gap = in_gaps_off ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_a  <= a;
        i_sample_b  <= b;
        i_last_pair <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // wait for every owed result, then let dropped pairs work through
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers in two back-to-back transactions; only while idle
    task automatic set_limit(input logic enable, input logic [DIST_BITS-1:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LIMIT_ENABLE;
        i_cfg_data  <= DIST_BITS'(enable);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_DIST_CEILING;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input t_sample_spread spread);
        case (spread)
            SPREAD_FULL:   return SAMPLE_BITS'($urandom);
            SPREAD_NARROW: return SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // reset values: limit off, so plain distances including the widest sample gap
    task automatic test_plain_distance();
        send_pair(S_MIN, S_MAX, 1'b1);
        send_pair(S_MAX, S_MIN, 1'b1);
        send_pair(0, 0, 1'b1);
        send_pair(3, 0, 1'b0);
        send_pair(0, 4, 1'b1);
        send_pair(-1, -1, 1'b0);
        send_pair(100, -100, 1'b1);
        send_pair(5, 7, 1'b0);
        send_pair(-2, 1, 1'b0);
        send_pair(10, 10, 1'b1);
        drain_results();
    endtask

    // abandon on the last pair, abandon mid-vector with dropped pairs,
    // the sum sitting exactly on the limit, and a zero limit
    task automatic test_abandon();
        set_limit(1'b1, 10);
        send_pair(0, 11, 1'b1);
        send_pair(0, 5, 1'b0);
        send_pair(0, 10, 1'b1);
        send_pair(0, 20, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(S_MIN, S_MAX, 1'b0);
        send_pair(1, 2, 1'b1);
        send_pair(0, 10, 1'b1);
        drain_results();
        set_limit(1'b1, 0);
        send_pair(7, 7, 1'b1);
        send_pair(S_MIN, S_MIN, 1'b1);
        send_pair(7, 8, 1'b1);
        drain_results();
    endtask

    // registers rewritten mid-vector and while pairs are being dropped
    task automatic test_mid_vector_writes();
        set_limit(1'b0, 0);
        send_pair(0, 100, 1'b0);
        drain_results();
        set_limit(1'b1, 50);
        send_pair(0, 0, 1'b1);
        drain_results();
        set_limit(1'b1, 5);
        send_pair(0, 9, 1'b0);
        send_pair(1, 2, 1'b0);
        drain_results();
        set_limit(1'b0, DIST_MAX);
        send_pair(3, 4, 1'b1);
        send_pair(6, 8, 1'b1);
        drain_results();
    endtask

    // widest limit must never abandon a short full-scale vector
    task automatic test_top_limit();
        set_limit(1'b1, DIST_MAX);
        send_pair(S_MIN, S_MAX, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair(S_MIN, S_MAX, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b1);
        drain_results();
    endtask

    // long full-scale vector with no idling on either side
    task automatic test_long_vector();
        set_limit(1'b0, DIST_MAX);
        in_gaps_off    = 1'b1;
        out_stalls_off = 1'b1;
        for (int i = 0; i < LONG_PAIRS; i++)
            send_pair(S_MIN, S_MAX, i == LONG_PAIRS - 1);
        drain_results();
        in_gaps_off    = 1'b0;
        out_stalls_off = 1'b0;
    endtask

    // phases of random vectors, each phase under its own register setting
    task automatic test_random_vectors();
        int                   sent;
        int                   len;
        logic                 enable;
        logic [DIST_BITS-1:0] limit;
        t_sample_spread       spread;
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            enable = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       limit = '0;
                1:       limit = DIST_MAX;
                2:       limit = DIST_BITS'($urandom_range(0, 255));
                3:       limit = DIST_BITS'($urandom_range(1000, 100000));
                4:       limit = DIST_BITS'($urandom);
                default: limit = DIST_BITS'($urandom_range(50, 3000));
            endcase
            set_limit(enable, limit);
            in_gaps_off    = ($urandom_range(0, 3) == 0);
            out_stalls_off = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       spread = SPREAD_FULL;
                1:       spread = SPREAD_NARROW;
                default: spread = SPREAD_EXTREME;
            endcase
            repeat (VECTORS_PER_PHASE) begin
                // mostly short vectors, now and then a long one
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_pair(draw_sample(spread), draw_sample(spread), i == len - 1);
                sent += len;
            end
            drain_results();
        end
        in_gaps_off    = 1'b0;
        out_stalls_off = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_distance();
        test_abandon();
        test_mid_vector_writes();
        test_top_limit();
        test_long_vector();
        test_random_vectors();
        drain_results();
        if (errors == 0)
            $display("early_abandon_euclidean_distance_unit_tb OK");
        else
            $display("early_abandon_euclidean_distance_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: early_abandon_euclidean_distance_unit.f
rtl/core/eaed_pkg.sv
rtl/core/eaed_isqrt.sv
rtl/core/eaed_datapath.sv
rtl/core/eaed_ctrl.sv
rtl/core/early_abandon_euclidean_distance_unit.sv
tb/early_abandon_euclidean_distance_unit_tb.sv
